[sv/stpc_pkg.sv]
// shared types, coefficient tables and fixed-point helpers for the sepia converter
`default_nettype none

package stpc_pkg;

    // pixel layouts selected by the format register
    typedef enum logic [2:0] {
        FMT_BGRA8   = 3'd0,
        FMT_ARGB8   = 3'd1,
        FMT_BGRA16  = 3'd2,
        FMT_ARGB16  = 3'd3,
        FMT_RGB10   = 3'd4,
        FMT_VUYA601 = 3'd5,
        FMT_VUYA709 = 3'd6
    } fmt_t;

    // coefficients scaled by 1e7, row major
    localparam longint K_TONE [9] = '{
        3930000, 7690000, 1890000,
        3490000, 6860000, 1680000,
        2720000, 5340000, 1310000
    };

    localparam longint K_RGB601 [9] = '{
        10000000, 0, 14075000,
        10000000, -3441400, -7169000,
        10000000, 17790000, 0
    };

    localparam longint K_RGB709 [9] = '{
        10000000, 0, 15748021,
        10000000, -1873270, -4681240,
        10000000, 18555993, 0
    };

    localparam longint K_YUV601 [9] = '{
        2990000, 5870000, 1140000,
        -1687360, -3312640, 5000000,
        5000000, -4186880, -813120
    };

    localparam longint K_YUV709 [9] = '{
        2126000, 7152000, 722000,
        -1145700, -3854300, 5000000,
        5000000, -4541500, -458500
    };

    // fixed-point coefficient, rounded half away from zero, frac_bits fraction bits
    function automatic longint qc(input longint k, input int frac_bits);
        longint scale;
        scale = longint'(1) << frac_bits;
        if (k >= 0)
        begin
            return (k * scale + 64'sd5000000) / 64'sd10000000;
        end
        else
        begin
            return -(((-k) * scale + 64'sd5000000) / 64'sd10000000);
        end
    endfunction

endpackage

`default_nettype wire

[sv/sepia_tone_pixel_converter.sv]
// sepia tone pixel converter: four-stage fixed-point color matrix pipeline
// Usage: one packed pixel per beat enters on the s_axis channel, the toned
// pixel in the same layout leaves on m_axis. The cfg channel writes the
// 3-bit pixel format (BGRA8, ARGB8, BGRA16, ARGB16, RGB10, VUYA8 601/709);
// write it only while no beat is in flight. cfg_ready is always high.
// Stages, from input beat to m_axis_tvalid: one each for YUV-to-RGB matrix,
// sepia matrix, RGB-to-YUV matrix, and shift/clamp/pack.
// Throughput: one beat per cycle while m_axis_tready is high; each matrix
// stage holds one multiply level of a 3x3 constant matrix and its row sums.
// Stall: each stage advances when it is empty or the next one moves, so a
// held m_axis_tready backs up stage by stage and s_axis_tready drops only
// when all four stages hold beats. Bubbles are squeezed out.
// Reset: all stages empty, format back to BGRA8. Alpha passes through;
// unused output bits are zero and format code 7 gives a zero pixel.
`default_nettype none

module sepia_tone_pixel_converter #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    // cfg: pixel format code
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    // s_axis_tdata: pixel_in[63:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    // m_axis_tdata: pixel_out[63:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata
);
    import stpc_pkg::*;

    localparam int F   = COEF_FRAC_BITS;
    localparam int CW  = F + 2;
    localparam int VW  = 17;
    localparam int S1W = F + 10;
    localparam int S2W = 2 * F + 11;
    localparam int TW  = F + 11;
    localparam int S3W = 2 * F + 11;
    localparam logic signed [S3W:0] TBIAS = (S3W + 1)'((longint'(1) << (2 * F)) - 1);

    // format register
    fmt_t fmt_reg;

    // stage valid bits and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // carried payload
    logic [63:0] pix1_reg, pix2_reg, pix3_reg;
    fmt_t        fmt1_reg, fmt2_reg, fmt3_reg;
    logic [63:0] out_reg, out_next;

    // coefficient constants
    logic signed [CW-1:0] tone_c   [9];
    logic signed [CW-1:0] rgb601_c [9];
    logic signed [CW-1:0] rgb709_c [9];
    logic signed [CW-1:0] yuv601_c [9];
    logic signed [CW-1:0] yuv709_c [9];
    logic signed [CW-1:0] id_c     [9];
    logic signed [CW-1:0] c1_sel   [9];
    logic signed [CW-1:0] c3_sel   [9];

    // datapath signals
    logic signed [VW-1:0]  vec1 [3];
    logic signed [8:0]     u9, v9;
    logic signed [S1W-1:0] s1   [3];
    logic signed [S2W-1:0] s2   [3];
    logic signed [TW-1:0]  t2   [3];
    logic signed [TW-1:0]  t3_reg [3];
    logic signed [S3W-1:0] s3   [3];
    logic signed [S3W:0]   adj  [3];
    logic signed [S3W:0]   shf  [3];
    logic signed [11:0]    oi   [3];
    logic [7:0]            yuv8 [3];
    logic [15:0]           rgbc [3];
    logic signed [TW-1:0]  maxs;

    assign cfg_ready = 1'b1;

    // constant tables at the chosen fraction width
    for (genvar gi = 0; gi < 9; gi++)
    begin : g_coef
        assign tone_c[gi]   = CW'(qc(K_TONE[gi], F));
        assign rgb601_c[gi] = CW'(qc(K_RGB601[gi], F));
        assign rgb709_c[gi] = CW'(qc(K_RGB709[gi], F));
        assign yuv601_c[gi] = CW'(qc(K_YUV601[gi], F));
        assign yuv709_c[gi] = CW'(qc(K_YUV709[gi], F));
        assign id_c[gi]     = (gi % 4 == 0) ? CW'(1) : CW'(0);
    end

    // format register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_BGRA8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fmt_reg <= fmt_t'(cfg_data);
        end
    end

    // per-stage enables, backward from the output
    assign en4 = !v4_reg || m_axis_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // unpack input beat into the first matrix operand
    assign u9 = $signed({1'b0, s_axis_tdata[15:8]}) - 9'sd128;
    assign v9 = $signed({1'b0, s_axis_tdata[7:0]}) - 9'sd128;

    always_comb
    begin
        vec1[0] = '0;
        vec1[1] = '0;
        vec1[2] = '0;
        c1_sel  = id_c;
        case (fmt_reg)
            FMT_BGRA8:
            begin
                vec1[0] = VW'({1'b0, s_axis_tdata[23:16]});
                vec1[1] = VW'({1'b0, s_axis_tdata[15:8]});
                vec1[2] = VW'({1'b0, s_axis_tdata[7:0]});
            end
            FMT_ARGB8:
            begin
                vec1[0] = VW'({1'b0, s_axis_tdata[15:8]});
                vec1[1] = VW'({1'b0, s_axis_tdata[23:16]});
                vec1[2] = VW'({1'b0, s_axis_tdata[31:24]});
            end
            FMT_BGRA16:
            begin
                vec1[0] = {1'b0, s_axis_tdata[47:32]};
                vec1[1] = {1'b0, s_axis_tdata[31:16]};
                vec1[2] = {1'b0, s_axis_tdata[15:0]};
            end
            FMT_ARGB16:
            begin
                vec1[0] = {1'b0, s_axis_tdata[31:16]};
                vec1[1] = {1'b0, s_axis_tdata[47:32]};
                vec1[2] = {1'b0, s_axis_tdata[63:48]};
            end
            FMT_RGB10:
            begin
                vec1[0] = VW'({1'b0, s_axis_tdata[31:22]});
                vec1[1] = VW'({1'b0, s_axis_tdata[21:12]});
                vec1[2] = VW'({1'b0, s_axis_tdata[11:2]});
            end
            FMT_VUYA601:
            begin
                vec1[0] = VW'({1'b0, s_axis_tdata[23:16]});
                vec1[1] = VW'(u9);
                vec1[2] = VW'(v9);
                c1_sel  = rgb601_c;
            end
            FMT_VUYA709:
            begin
                vec1[0] = VW'({1'b0, s_axis_tdata[23:16]});
                vec1[1] = VW'(u9);
                vec1[2] = VW'(v9);
                c1_sel  = rgb709_c;
            end
            default:
            begin
                c1_sel = id_c;
            end
        endcase
    end

    // stage 1: yuv to rgb (identity in rgb formats)
    stpc_mat3 #(
        .VW (VW),
        .CW (CW),
        .SW (S1W)
    ) u_mat_rgb (
        .clk  (clk),
        .en   (en1),
        .vec  (vec1),
        .coef (c1_sel),
        .sum  (s1)
    );

    // stage 2: sepia matrix
    stpc_mat3 #(
        .VW (S1W),
        .CW (CW),
        .SW (S2W)
    ) u_mat_tone (
        .clk  (clk),
        .en   (en2),
        .vec  (s1),
        .coef (tone_c),
        .sum  (s2)
    );

    // floor shift of the toned values, and stage 3 coefficient pick
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t2[k] = s2[k][S2W-1:F];
        end
        if (fmt2_reg == FMT_VUYA709)
        begin
            c3_sel = yuv709_c;
        end
        else
        begin
            c3_sel = yuv601_c;
        end
    end

    // stage 3: rgb back to yuv
    stpc_mat3 #(
        .VW (TW),
        .CW (CW),
        .SW (S3W)
    ) u_mat_yuv (
        .clk  (clk),
        .en   (en3),
        .vec  (t2),
        .coef (c3_sel),
        .sum  (s3)
    );

    // payload carried alongside the matrix stages
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            pix1_reg <= s_axis_tdata;
            fmt1_reg <= fmt_reg;
        end
        if (en2)
        begin
            pix2_reg <= pix1_reg;
            fmt2_reg <= fmt1_reg;
        end
        if (en3)
        begin
            pix3_reg <= pix2_reg;
            fmt3_reg <= fmt2_reg;
            t3_reg   <= t2;
        end
        if (en4)
        begin
            out_reg <= out_next;
        end
    end

    // yuv: truncate toward zero, chroma offset, clamp to 8 bits
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            adj[k] = (S3W + 1)'(s3[k]) + ((s3[k] < 0) ? TBIAS : '0);
            shf[k] = adj[k] >>> (2 * F);
            oi[k]  = shf[k][11:0] + ((k == 0) ? 12'sd0 : 12'sd128);
            if (oi[k] < 0)
            begin
                yuv8[k] = 8'd0;
            end
            else if (oi[k] > 12'sd255)
            begin
                yuv8[k] = 8'd255;
            end
            else
            begin
                yuv8[k] = oi[k][7:0];
            end
        end
    end

    // rgb: clamp to the channel maximum of the format
    always_comb
    begin
        case (fmt3_reg)
            FMT_BGRA16, FMT_ARGB16: maxs = TW'(17'd65535);
            FMT_RGB10:              maxs = TW'(17'd1023);
            default:                maxs = TW'(17'd255);
        endcase
        for (int k = 0; k < 3; k++)
        begin
            if (t3_reg[k] < 0)
            begin
                rgbc[k] = 16'd0;
            end
            else if (t3_reg[k] > maxs)
            begin
                rgbc[k] = maxs[15:0];
            end
            else
            begin
                rgbc[k] = t3_reg[k][15:0];
            end
        end
    end

    // stage 4: pack into the source layout
    always_comb
    begin
        case (fmt3_reg)
            FMT_BGRA8:
                out_next = {32'd0, pix3_reg[31:24], rgbc[0][7:0], rgbc[1][7:0],
                            rgbc[2][7:0]};
            FMT_ARGB8:
                out_next = {32'd0, rgbc[2][7:0], rgbc[1][7:0], rgbc[0][7:0],
                            pix3_reg[7:0]};
            FMT_BGRA16:
                out_next = {pix3_reg[63:48], rgbc[0], rgbc[1], rgbc[2]};
            FMT_ARGB16:
                out_next = {rgbc[2], rgbc[1], rgbc[0], pix3_reg[15:0]};
            FMT_RGB10:
                out_next = {32'd0, rgbc[0][9:0], rgbc[1][9:0], rgbc[2][9:0], 2'b00};
            FMT_VUYA601, FMT_VUYA709:
                out_next = {32'd0, pix3_reg[31:24], yuv8[0], yuv8[1], yuv8[2]};
            default:
                out_next = 64'd0;
        endcase
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = out_reg;

    // input stalls only when every stage is occupied
    a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with an empty stage");

    // a beat waiting behind a stalled output is kept
    a_hold_stage3: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && v4_reg && !m_axis_tready) |=> v3_reg)
        else $error("stage 3 beat lost under stall");

    // an accepted beat lands in stage 1
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("accepted beat missing from stage 1");

endmodule

`default_nettype wire

[sv/stpc_mat3.sv]
// registered 3x3 signed matrix-vector product with stall enable
`default_nettype none

module stpc_mat3 #(
    parameter int VW = 17,
    parameter int CW = 16,
    parameter int SW = 24
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [VW-1:0] vec  [3],
    input  logic signed [CW-1:0] coef [9],
    output logic signed [SW-1:0] sum  [3]
);
    import stpc_pkg::*;

    localparam int PW = VW + CW;

    logic signed [PW-1:0] prod     [9];
    logic signed [PW+1:0] acc      [3];
    logic signed [SW-1:0] sum_next [3];
    logic signed [SW-1:0] sum_reg  [3];

    // nine products, one per coefficient
    always_comb
    begin
        for (int j = 0; j < 9; j++)
        begin
            prod[j] = PW'(vec[j % 3]) * PW'(coef[j]);
        end
    end

    // row sums, cut to the result width (values stay in range)
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc[k] = (PW + 2)'(prod[3 * k]) + (PW + 2)'(prod[3 * k + 1])
                   + (PW + 2)'(prod[3 * k + 2]);
            sum_next[k] = acc[k][SW-1:0];
        end
    end

    // result register, holds on stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire
